// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define NLC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("nlc assertion failed");

// A payload stalled at a valid edge still stands at the next edge.
`define NLC_ASSERT_HOLD(lbl, clk, rst, vld, stl, sig) \
  `NLC_ASSERT(lbl, clk, rst, ((vld) && (stl)) |=> ((vld) && $stable(sig)))

`endif

// ===== sv/nlc_pkg.sv =====
// Package: state codes, verdict codes, character constants and result type.
package nlc_pkg;

  localparam int MAX_LEN = 255;
  localparam logic [7:0] LEN_CAP = (MAX_LEN > 255) ? 8'd255 : 8'(MAX_LEN);

  typedef logic [4:0] state_t;

  localparam state_t ST_ZERO     = 5'd0;
  localparam state_t ST_NORMAL   = 5'd1;
  localparam state_t ST_HEX1     = 5'd2;
  localparam state_t ST_HEX2     = 5'd3;
  localparam state_t ST_FLOAT    = 5'd4;
  localparam state_t ST_EXP1     = 5'd5;
  localparam state_t ST_EXP2     = 5'd6;
  localparam state_t ST_EXP3     = 5'd7;
  localparam state_t ST_END_INT  = 5'd8;
  localparam state_t ST_END_LONG = 5'd9;
  localparam state_t ST_END_HEX  = 5'd10;
  localparam state_t ST_END_LHEX = 5'd11;
  localparam state_t ST_END_FLT  = 5'd12;
  localparam state_t ST_END_FLTE = 5'd13;
  localparam state_t ST_END_DBL  = 5'd14;
  localparam state_t ST_END_DBLE = 5'd15;
  localparam state_t ST_BAD      = 5'd16;
  localparam state_t ST_BAD_HEX  = 5'd17;
  localparam state_t ST_BAD_EXP  = 5'd18;
  localparam state_t ST_IDLE     = 5'd19;

  localparam logic [1:0] V_ACCEPT  = 2'd0;
  localparam logic [1:0] V_REFUSE  = 2'd1;
  localparam logic [1:0] V_ERROR   = 2'd2;
  localparam logic [1:0] V_NOSTART = 2'd3;

  localparam logic [3:0] K_NONE  = 4'd0;
  localparam logic [3:0] K_INT   = 4'd1;
  localparam logic [3:0] K_LONG  = 4'd2;
  localparam logic [3:0] K_HEX   = 4'd3;
  localparam logic [3:0] K_LHEX  = 4'd4;
  localparam logic [3:0] K_FLT   = 4'd5;
  localparam logic [3:0] K_FLTE  = 4'd6;
  localparam logic [3:0] K_DBL   = 4'd7;
  localparam logic [3:0] K_DBLE  = 4'd8;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_TRAILING = 2'd1;
  localparam logic [1:0] E_BAD_HEX  = 2'd2;
  localparam logic [1:0] E_BAD_EXP  = 2'd3;

  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UF    = "F";
  localparam logic [7:0] CH_UZ    = "Z";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LF    = "f";
  localparam logic [7:0] CH_LZ    = "z";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_UX    = "X";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_LL    = "l";
  localparam logic [7:0] CH_UL    = "L";
  localparam logic [7:0] CH_LE    = "e";
  localparam logic [7:0] CH_UE    = "E";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_HIGH  = 8'h80;

  typedef struct packed {
    logic [1:0] verdict;
    logic [3:0] literal_kind;
    logic [1:0] error_class;
    logic [7:0] literal_length;
  } nlc_result_t;

  function automatic logic [3:0] kind_of(input state_t s);
    logic [3:0] k;
    case (s)
      ST_ZERO, ST_NORMAL, ST_END_INT: k = K_INT;
      ST_HEX2, ST_END_HEX:            k = K_HEX;
      ST_FLOAT, ST_END_DBL:           k = K_DBL;
      ST_EXP3, ST_END_DBLE:           k = K_DBLE;
      ST_END_LONG:                    k = K_LONG;
      ST_END_LHEX:                    k = K_LHEX;
      ST_END_FLT:                     k = K_FLT;
      ST_END_FLTE:                    k = K_FLTE;
      default:                        k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] class_of(input state_t s);
    logic [1:0] c;
    case (s)
      ST_BAD:     c = E_TRAILING;
      ST_BAD_HEX: c = E_BAD_HEX;
      ST_BAD_EXP: c = E_BAD_EXP;
      default:    c = E_NONE;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/nlc_step.sv =====
// One recognizer transition: next state, next length and the result fields.
module nlc_step import nlc_pkg::*; (
  input  logic [7:0]  char_code,
  input  logic        first,
  input  state_t      scan_state,
  input  logic [7:0]  accepted_count,
  output state_t      state_next,
  output logic [7:0]  count_next,
  output nlc_result_t result
);

  logic   is_dig, is_hex, is_word, is_e, is_f, is_l;
  logic   acc;
  logic   [1:0] vrd;
  state_t st;

  always_comb begin
    is_dig  = char_code inside {[CH_0:CH_9]};
    is_hex  = is_dig || (char_code inside {[CH_UA:CH_UF], [CH_LA:CH_LF]});
    is_word = (char_code inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ], CH_UNDER})
              || (char_code >= CH_HIGH);
    is_e    = char_code inside {CH_LE, CH_UE};
    is_f    = char_code inside {CH_LF, CH_UF};
    is_l    = char_code inside {CH_LL, CH_UL};
    st      = scan_state;
    acc     = 1'b0;
    vrd     = V_ERROR;

    if (first) begin
      if (is_dig) begin
        st  = (char_code == CH_0) ? ST_ZERO : ST_NORMAL;
        vrd = V_ACCEPT;
      end else begin
        st  = ST_IDLE;
        vrd = V_NOSTART;
      end
    end else begin
      case (scan_state)
        ST_ZERO, ST_NORMAL: begin
          if (scan_state == ST_ZERO && (char_code inside {CH_LX, CH_UX})) begin
            st = ST_HEX1; acc = 1'b1;
          end else if (char_code == CH_DOT) begin
            st = ST_FLOAT; acc = 1'b1;
          end else if (is_dig) begin
            st = ST_NORMAL; acc = 1'b1;
          end else if (is_l) begin
            st = ST_END_LONG; acc = 1'b1;
          end else if (is_e) begin
            st = ST_EXP1; acc = 1'b1;
          end else if (is_word) begin
            st = ST_BAD;
          end else begin
            st = ST_END_INT; vrd = V_REFUSE;
          end
        end
        ST_HEX1: begin
          if (is_hex) begin
            st = ST_HEX2; acc = 1'b1;
          end else begin
            st = ST_BAD_HEX;
          end
        end
        ST_HEX2: begin
          if (is_l) begin
            st = ST_END_LHEX; acc = 1'b1;
          end else if (is_hex) begin
            acc = 1'b1;
          end else if (is_word) begin
            st = ST_BAD;
          end else begin
            st = ST_END_HEX; vrd = V_REFUSE;
          end
        end
        ST_FLOAT: begin
          if (is_f) begin
            st = ST_END_FLT; acc = 1'b1;
          end else if (is_e) begin
            st = ST_EXP1; acc = 1'b1;
          end else if (is_word) begin
            st = ST_BAD;
          end else if (!is_dig) begin
            st = ST_END_DBL; vrd = V_REFUSE;
          end else begin
            acc = 1'b1;
          end
        end
        ST_EXP1: begin
          if (char_code inside {CH_PLUS, CH_MINUS}) begin
            st = ST_EXP2; acc = 1'b1;
          end else if (is_dig) begin
            st = ST_EXP3; acc = 1'b1;
          end else begin
            st = ST_BAD_EXP;
          end
        end
        ST_EXP2: begin
          if (is_dig) begin
            st = ST_EXP3; acc = 1'b1;
          end else begin
            st = ST_BAD_EXP;
          end
        end
        ST_EXP3: begin
          if (is_f) begin
            st = ST_END_FLTE; acc = 1'b1;
          end else if (is_word) begin
            st = ST_BAD;
          end else if (!is_dig) begin
            st = ST_END_DBLE; vrd = V_REFUSE;
          end else begin
            acc = 1'b1;
          end
        end
        ST_END_FLT, ST_END_FLTE, ST_END_LHEX, ST_END_LONG: begin
          // suffix seen: glued digits and word chars are errors, anything else ends it
          if (is_dig || is_word) begin
            st = ST_BAD;
          end else begin
            vrd = V_REFUSE;
          end
        end
        ST_IDLE: vrd = V_NOSTART;
        default: vrd = V_ERROR;
      endcase
      if (acc) begin
        vrd = V_ACCEPT;
      end
    end

    if (st > ST_IDLE) begin
      st = ST_IDLE;
    end
  end

  assign state_next = st;

  always_comb begin
    if (first) begin
      count_next = is_dig ? 8'd1 : 8'd0;
    end else if (acc && (accepted_count < LEN_CAP)) begin
      count_next = accepted_count + 8'd1;
    end else begin
      count_next = accepted_count;
    end
  end

  assign result.verdict        = vrd;
  assign result.literal_kind   = kind_of(st);
  assign result.error_class    = class_of(st);
  assign result.literal_length = (st == ST_IDLE) ? 8'd0 : count_next;

endmodule

// ===== sv/number_literal_classifier.sv =====
// Top level: input register, recognizer step and two-entry result buffer.
//
// number_literal_classifier scans C-style numeric literals one byte per
// request. A request with first set opens a new literal; each byte returns
// one result: verdict (accepted, refused, error, not a number start), the
// kind the literal would have if it ended here, the error class and the
// saturating length. Throughput is one byte per clock while in_stall is
// low: the only feedback loop is the single-step transition of the 5-bit
// scan state and the 8-bit length counter. A byte lands in the input
// register at the edge that accepts it; when it leaves that register its
// result is registered into the main result register, or into the skid
// register if main is full and not popped. The result side has a main
// register and a skid register, so a request is still taken while one
// result waits on out_stall; in_stall rises only when both output registers
// are full and a byte sits in the input register. After reset the
// recognizer acts as if a lone '0' had been seen, with a length of 0.
module number_literal_classifier import nlc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       first,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] verdict,
  output logic [3:0] literal_kind,
  output logic [1:0] error_class,
  output logic [7:0] literal_length
);

  // input register
  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_first;

  // recognizer state
  state_t      scan_state;
  logic [7:0]  accepted_count;
  state_t      state_next;
  logic [7:0]  count_next;
  nlc_result_t step_res;

  // result buffer: main register drives the ports, skid catches one more
  logic        main_valid;
  nlc_result_t main_res;
  logic        skid_valid;
  nlc_result_t skid_res;

  logic        in_take;
  logic        move;
  logic        pop;

  assign in_stall = s1_valid && skid_valid;
  assign in_take  = in_valid && !in_stall;
  assign move     = s1_valid && !skid_valid;
  assign pop      = main_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !move);
    end
    if (in_take) begin
      s1_char  <= char_code;
      s1_first <= first;
    end
  end

  nlc_step u_step (
    .char_code      (s1_char),
    .first          (s1_first),
    .scan_state     (scan_state),
    .accepted_count (accepted_count),
    .state_next     (state_next),
    .count_next     (count_next),
    .result         (step_res)
  );

  // state advances when the byte leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state     <= ST_ZERO;
      accepted_count <= 8'd0;
    end else if (move) begin
      scan_state     <= state_next;
      accepted_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no push possible while skid is full
      if (pop) begin
        main_res   <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (move) begin
      if (!main_valid || pop) begin
        main_res   <= step_res;
        main_valid <= 1'b1;
      end else begin
        skid_res   <= step_res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  assign out_valid      = main_valid;
  assign verdict        = main_res.verdict;
  assign literal_kind   = main_res.literal_kind;
  assign error_class    = main_res.error_class;
  assign literal_length = main_res.literal_length;

endmodule

// ===== sv/nlc_checker.sv =====
// Port-level checker for number_literal_classifier, bound to the top level.
`include "assert_macros.svh"

module nlc_checker import nlc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] char_code,
  input logic       first,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] verdict,
  input logic [3:0] literal_kind,
  input logic [1:0] error_class,
  input logic [7:0] literal_length
);

  logic [15:0] out_bundle;
  logic [8:0]  in_bundle;
  logic        nostart_seen;
  logic        fields_clear;
  logic        err_seen;
  logic        err_plain;
  logic        acc_seen;

  assign out_bundle   = {verdict, literal_kind, error_class, literal_length};
  assign in_bundle    = {char_code, first};
  assign nostart_seen = out_valid && (verdict == V_NOSTART);
  assign fields_clear = (literal_kind == K_NONE) && (error_class == E_NONE) &&
                        (literal_length == 8'd0);
  assign err_seen     = out_valid && (error_class != E_NONE);
  assign err_plain    = (literal_kind == K_NONE) && (verdict == V_ERROR);
  assign acc_seen     = out_valid && (verdict == V_ACCEPT);

  `NLC_ASSERT_HOLD(a_in_hold, clk, rst, in_valid, in_stall, in_bundle)
  `NLC_ASSERT_HOLD(a_out_hold, clk, rst, out_valid, out_stall, out_bundle)
  `NLC_ASSERT(a_nostart_clean, clk, rst, nostart_seen |-> fields_clear)
  `NLC_ASSERT(a_err_no_kind, clk, rst, err_seen |-> err_plain)
  `NLC_ASSERT(a_accept_len, clk, rst, acc_seen |-> (literal_length != 8'd0))

endmodule

bind number_literal_classifier nlc_checker u_nlc_checker (.*);

// ===== sim/number_literal_classifier_tb.sv =====
// Testbench for number_literal_classifier: byte-stream stimulus, scan predictor, result checks.
module number_literal_classifier_tb;
  import nlc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog: a little over a thousand requests, most with random gaps, taken many times over.
  localparam int CYCLE_LIMIT = 200000;
  // Roughly 38 percent idle on each side while gaps are enabled.
  localparam int IDLE_PCT = 38;
  // A separator byte that is neither a digit nor a letter: ends a literal cleanly.
  localparam logic [7:0] CH_SPACE = " ";

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_code = 8'd0;
  logic       first = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] verdict;
  logic [3:0] literal_kind;
  logic [1:0] error_class;
  logic [7:0] literal_length;

  // Predictor copy of the recognizer state.
  state_t     scan_st = ST_ZERO;
  logic [7:0] lit_len = 8'd0;

  nlc_result_t expected_results[$];
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  bit          gaps_on = 1'b1;

  number_literal_classifier dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .first(first),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict),
    .literal_kind(literal_kind),
    .error_class(error_class),
    .literal_length(literal_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Character classes used by the scan predictor.
  // ---------------------------------------------------------------------------
  function automatic bit is_dec(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_hex_digit(input logic [7:0] c);
    return is_dec(c) || (c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF);
  endfunction

  // Letters, underscore and every byte with the top bit set glue onto a literal.
  function automatic bit is_word_char(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
           c[7] || c == CH_UNDER;
  endfunction

  // Kind the literal would have if it ended in state s; none where it cannot end.
  function automatic logic [3:0] kind_after(input state_t s);
    case (s)
      ST_ZERO, ST_NORMAL, ST_END_INT: return K_INT;
      ST_END_LONG:                    return K_LONG;
      ST_HEX2, ST_END_HEX:            return K_HEX;
      ST_END_LHEX:                    return K_LHEX;
      ST_END_FLT:                     return K_FLT;
      ST_END_FLTE:                    return K_FLTE;
      ST_FLOAT, ST_END_DBL:           return K_DBL;
      ST_EXP3, ST_END_DBLE:           return K_DBLE;
      default:                        return K_NONE;
    endcase
  endfunction

  function automatic logic [1:0] error_after(input state_t s);
    case (s)
      ST_BAD:     return E_TRAILING;
      ST_BAD_HEX: return E_BAD_HEX;
      ST_BAD_EXP: return E_BAD_EXP;
      default:    return E_NONE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Scan predictor: advances the local state by one byte and returns the
  // result the block must produce for it.
  // ---------------------------------------------------------------------------
  function automatic nlc_result_t scan_next_byte(input logic [7:0] c, input logic f);
    nlc_result_t r;
    logic [1:0]  v;
    state_t      nxt;
    bit          take;
    v    = V_ACCEPT;
    nxt  = scan_st;
    take = 1'b0;
    if (f) begin
      // A start byte clears everything; only a digit opens a literal.
      lit_len = 8'd0;
      if (is_dec(c)) begin
        lit_len = 8'd1;
        nxt = (c == CH_0) ? ST_ZERO : ST_NORMAL;
      end else begin
        nxt = ST_IDLE;
        v   = V_NOSTART;
      end
    end else begin
      case (scan_st)
        ST_ZERO, ST_NORMAL: begin
          if (scan_st == ST_ZERO && (c == CH_LX || c == CH_UX)) begin
            nxt = ST_HEX1; take = 1'b1;
          end else if (c == CH_DOT) begin
            nxt = ST_FLOAT; take = 1'b1;
          end else if (is_dec(c)) begin
            nxt = ST_NORMAL; take = 1'b1;
          end else if (c == CH_LL || c == CH_UL) begin
            nxt = ST_END_LONG; take = 1'b1;
          end else if (c == CH_LE || c == CH_UE) begin
            nxt = ST_EXP1; take = 1'b1;
          end else if (is_word_char(c)) begin
            nxt = ST_BAD; v = V_ERROR;
          end else begin
            nxt = ST_END_INT; v = V_REFUSE;
          end
        end
        ST_HEX1: begin
          if (is_hex_digit(c)) begin
            nxt = ST_HEX2; take = 1'b1;
          end else begin
            nxt = ST_BAD_HEX; v = V_ERROR;
          end
        end
        ST_HEX2: begin
          if (c == CH_LL || c == CH_UL) begin
            nxt = ST_END_LHEX; take = 1'b1;
          end else if (is_hex_digit(c)) begin
            take = 1'b1;
          end else if (is_word_char(c)) begin
            nxt = ST_BAD; v = V_ERROR;
          end else begin
            nxt = ST_END_HEX; v = V_REFUSE;
          end
        end
        ST_FLOAT: begin
          if (c == CH_LF || c == CH_UF) begin
            nxt = ST_END_FLT; take = 1'b1;
          end else if (c == CH_LE || c == CH_UE) begin
            nxt = ST_EXP1; take = 1'b1;
          end else if (is_word_char(c)) begin
            nxt = ST_BAD; v = V_ERROR;
          end else if (is_dec(c)) begin
            take = 1'b1;
          end else begin
            nxt = ST_END_DBL; v = V_REFUSE;
          end
        end
        ST_EXP1: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            nxt = ST_EXP2; take = 1'b1;
          end else if (is_dec(c)) begin
            nxt = ST_EXP3; take = 1'b1;
          end else begin
            nxt = ST_BAD_EXP; v = V_ERROR;
          end
        end
        ST_EXP2: begin
          if (is_dec(c)) begin
            nxt = ST_EXP3; take = 1'b1;
          end else begin
            nxt = ST_BAD_EXP; v = V_ERROR;
          end
        end
        ST_EXP3: begin
          if (c == CH_LF || c == CH_UF) begin
            nxt = ST_END_FLTE; take = 1'b1;
          end else if (is_word_char(c)) begin
            nxt = ST_BAD; v = V_ERROR;
          end else if (is_dec(c)) begin
            take = 1'b1;
          end else begin
            nxt = ST_END_DBLE; v = V_REFUSE;
          end
        end
        // After a suffix: glued characters are errors, anything else is refused.
        ST_END_FLT, ST_END_FLTE, ST_END_LHEX, ST_END_LONG: begin
          if (is_dec(c) || is_word_char(c)) begin
            nxt = ST_BAD; v = V_ERROR;
          end else begin
            v = V_REFUSE;
          end
        end
        ST_IDLE: v = V_NOSTART;
        // Plain ends and error states: error, nothing moves.
        default: v = V_ERROR;
      endcase
      if (take && lit_len < LEN_CAP) lit_len = lit_len + 8'd1;
    end
    scan_st          = nxt;
    r.verdict        = v;
    r.literal_kind   = kind_after(nxt);
    r.error_class    = error_after(nxt);
    r.literal_length = (nxt == ST_IDLE) ? 8'd0 : lit_len;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. in_valid is left high after an accept; the next call either
  // drops it for a gap or presents the next byte, so each step sees one write.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic f);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    first     <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results = {expected_results, scan_next_byte(c, f)};
    bytes_sent++;
  endtask

  // Sends a text; the first character opens a literal when opens is set.
  task automatic send_text(input string s, input bit opens);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], opens && i == 0);
  endtask

  // Holds off requests until every outstanding result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stall, and an in-order compare of each accepted result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    nlc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d", $time,
                 verdict, literal_kind, error_class, literal_length);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("verdict", want.verdict, verdict);
        check_field("literal_kind", want.literal_kind, literal_kind);
        check_field("error_class", want.error_class, error_class);
        check_field("literal_length", want.literal_length, literal_length);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the recognizer sits as if a lone zero had been seen, with
  // no bytes counted: an 'x' without a start opens a hex literal. The refused
  // ';' is followed by a byte after a plain end, which must be an error.
  task automatic test_reset_state();
    send_text("x7;a", 1'b0);
  endtask

  // Short directed list: non-digit start, idle recognizer, trailing underscore,
  // bad hex digit, float exponent with suffix then a glued digit, bad exponent
  // sign sequence, long suffix followed by a high byte.
  task automatic test_directed_cases();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_text("9_", 1'b1);
    send_text("0xg", 1'b1);
    send_text("1e+5f1", 1'b1);
    send_text("2.e-z", 1'b1);
    send_text("7L", 1'b1);
    send_byte(CH_HIGH, 1'b0);
  endtask

  // A literal longer than the counter: the length must stick at its cap.
  task automatic test_length_saturation();
    send_byte(CH_0 + 8'd1, 1'b1);
    repeat (299) send_byte(CH_0 + 8'($urandom_range(9)), 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_9, 1'b0);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_one(input string pool);
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  // Mostly well-formed literals (int, hex, float, exponent forms with suffixes)
  // followed by random terminator bytes; some get one byte corrupted, and a
  // tenth of the time a lone random byte with a random start flag is sent.
  task automatic test_random_literals(input int target, input bit with_gaps);
    logic [7:0] lit[$];
    int         base;
    int         form;
    base    = bytes_sent;
    gaps_on = with_gaps;
    while (bytes_sent - base < target) begin
      lit.delete();
      form = $urandom_range(9);
      if (form == 0) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        continue;
      end
      case (form)
        1, 2: begin
          lit = {lit, rand_digit()};
          repeat ($urandom_range(4)) lit = {lit, rand_digit()};
          if ($urandom_range(2) == 0) lit = {lit, $urandom_range(1) ? CH_LL : CH_UL};
        end
        3, 4: begin
          lit = {lit, CH_0};
          lit = {lit, $urandom_range(1) ? CH_LX : CH_UX};
          repeat ($urandom_range(1, 4)) lit = {lit, pick_one("0123456789abcdefABCDEF")};
          if ($urandom_range(2) == 0) lit = {lit, $urandom_range(1) ? CH_LL : CH_UL};
        end
        default: begin
          lit = {lit, rand_digit()};
          repeat ($urandom_range(3)) lit = {lit, rand_digit()};
          // forms 5..7 carry a fraction, 8..9 go straight to the exponent
          if (form <= 7) begin
            lit = {lit, CH_DOT};
            repeat ($urandom_range(3)) lit = {lit, rand_digit()};
          end
          if (form >= 8 || $urandom_range(1)) begin
            lit = {lit, $urandom_range(1) ? CH_LE : CH_UE};
            case ($urandom_range(2))
              1: lit = {lit, CH_PLUS};
              2: lit = {lit, CH_MINUS};
              default: ;
            endcase
            repeat ($urandom_range(1, 3)) lit = {lit, rand_digit()};
          end
          if ($urandom_range(2) == 0) lit = {lit, $urandom_range(1) ? CH_LF : CH_UF};
        end
      endcase
      repeat ($urandom_range(1, 3)) lit = {lit, 8'($urandom_range(255))};
      // Broken sequences: one byte replaced by a random or a structural character.
      if ($urandom_range(99) < 15)
        lit[$urandom_range(lit.size() - 1)] = $urandom_range(1) ?
            8'($urandom_range(255)) : pick_one(".xXlLeEfF+-_09");
      foreach (lit[i]) send_byte(lit[i], i == 0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_cases();
    drain_results();
    test_length_saturation();
    drain_results();
    test_random_literals(600, 1'b1);
    drain_results();
    // Long stretch with neither side idling.
    test_random_literals(220, 1'b0);
    drain_results();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
